// ----- rtl/bmpu_pkg.sv -----
package bmpu_pkg;

  // Limits of the clamped configuration.
  localparam int MAX_SCALE  = 32;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field and register widths.
  localparam int COLOR_W = 8;
  localparam int SCALE_W = 6;
  localparam int DIM_W   = 13;
  localparam int COL_W   = 12;
  localparam int PASS_W  = 5;
  localparam int ROW_W   = 12;
  localparam int PAD_W   = 2;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Depth of the command queue between front and back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  // One classified pixel: what the back end has to emit for it.
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [SCALE_W-1:0] copies;
    logic [SCALE_W-1:0] last_idx;
    logic               row_last;
    logic               image_last;
  } cmd_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Zero reads as one, anything above the limit saturates.
  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    if (v == '0) begin
      r = SCALE_W'(1);
    end else if (v > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/bmpu_pix_if.sv -----
interface bmpu_pix_if;
  import bmpu_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// ----- rtl/bmpu_res_if.sv -----
interface bmpu_res_if;
  import bmpu_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COLOR_W-1:0] blue_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] red_out;
  logic               run_last;
  logic               row_end;
  logic               image_end;

  modport source (output valid, output kind, output blue_out, output green_out,
                  output red_out, output run_last, output row_end, output image_end,
                  input ready);
  modport sink   (input valid, input kind, input blue_out, input green_out,
                  input red_out, input run_last, input row_end, input image_end,
                  output ready);
endinterface

// ----- rtl/bmpu_front.sv -----
module bmpu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  bmpu_pix_if.sink                      in_pix,
  input  logic                          cfg_we,
  input  logic [bmpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmpu_pkg::CFG_W-1:0]    cfg_data,
  input  bmpu_pkg::qstat_t              qstat,
  output logic                          push,
  output bmpu_pkg::cmd_t                push_cmd
);
  import bmpu_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [PASS_W-1:0]  pass_r, pass_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               done_r, done_nxt;

  logic [SCALE_W-1:0] s_c;
  logic [DIM_W-1:0]   w_c;
  logic [DIM_W-1:0]   h_c;
  logic [3:0]         ws_lo;
  logic [3:0]         bytes_lo;
  logic [PAD_W-1:0]   pad;
  logic               row_last;
  logic               pass_last;
  logic               image_last;
  logic               accept;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_W'(1);
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:  scale_r  <= cfg_data[SCALE_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry and row padding; only the low two bits of
  // width*scale decide the padding count.
  always_comb begin
    s_c      = clamp_scale(scale_r);
    w_c      = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
    h_c      = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));
    ws_lo    = {2'b00, w_c[1:0]} * {2'b00, s_c[1:0]};
    bytes_lo = {2'b00, ws_lo[1:0]} * 4'd3;
    pad      = PAD_W'(2'd0 - bytes_lo[1:0]);
  end

  // Pixels after the final row are accepted and dropped.
  assign in_pix.ready = !qstat.full;
  assign accept       = in_pix.valid && in_pix.ready;
  assign push         = accept && !done_r;

  // Position classification; a counter past its limit counts as at it.
  always_comb begin
    row_last   = {1'b0, col_r} >= (w_c - DIM_W'(1));
    pass_last  = {1'b0, pass_r} >= (s_c - SCALE_W'(1));
    image_last = row_last && pass_last && ({1'b0, row_r} >= (h_c - DIM_W'(1)));

    col_nxt  = col_r;
    pass_nxt = pass_r;
    row_nxt  = row_r;
    done_nxt = done_r;
    if (push) begin
      if (row_last) begin
        col_nxt = '0;
        if (pass_last) begin
          pass_nxt = '0;
          if (image_last) begin
            row_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            row_nxt = ROW_W'(row_r + ROW_W'(1));
          end
        end else begin
          pass_nxt = PASS_W'(pass_r + PASS_W'(1));
        end
      end else begin
        col_nxt = COL_W'(col_r + COL_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      pass_r <= '0;
      row_r  <= '0;
      done_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      pass_r <= pass_nxt;
      row_r  <= row_nxt;
      done_r <= done_nxt;
    end
  end

  // Command for the back end: copies, then padding on a row end.
  always_comb begin
    push_cmd.blue       = in_pix.blue;
    push_cmd.green      = in_pix.green;
    push_cmd.red        = in_pix.red;
    push_cmd.copies     = s_c;
    push_cmd.last_idx   = SCALE_W'(s_c - SCALE_W'(1) + (row_last ? {4'b0, pad} : '0));
    push_cmd.row_last   = row_last;
    push_cmd.image_last = image_last;
  end

  // Nothing is queued once the image is complete.
  a_no_push_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !push) else $error("command queued after image end");

endmodule

// ----- rtl/bmpu_queue.sv -----
module bmpu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bmpu_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output bmpu_pkg::cmd_t   pop_cmd,
  output bmpu_pkg::qstat_t qstat
);
  import bmpu_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_cmd     = mem_r[rd_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_nxt  = push ? QPTR_W'(wr_r + QPTR_W'(1)) : wr_r;
    rd_nxt  = pop  ? QPTR_W'(rd_r + QPTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_W'(cnt_r + QCNT_W'(1));
    end else if (pop && !push) begin
      cnt_nxt = QCNT_W'(cnt_r - QCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("pop from empty queue");

endmodule

// ----- rtl/bmpu_back.sv -----
module bmpu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bmpu_pkg::cmd_t   pop_cmd,
  input  bmpu_pkg::qstat_t qstat,
  output logic             pop,
  bmpu_res_if.source       out_res
);
  import bmpu_pkg::*;

  cmd_t               cur_r, cur_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [SCALE_W-1:0] idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [COLOR_W-1:0] blue_r, blue_nxt;
  logic [COLOR_W-1:0] green_r, green_nxt;
  logic [COLOR_W-1:0] red_r, red_nxt;
  logic               run_last_r, run_last_nxt;
  logic               row_end_r, row_end_nxt;
  logic               image_end_r, image_end_nxt;

  logic advance;
  logic is_last;
  logic cur_done;
  logic is_pad;

  // The result register moves when empty or when its beat is taken.
  assign advance  = !out_valid_r || out_res.ready;
  assign is_last  = (idx_r == cur_r.last_idx);
  assign is_pad   = (idx_r >= cur_r.copies);
  assign cur_done = cur_valid_r && advance && is_last;
  assign pop      = !qstat.empty && (!cur_valid_r || cur_done);

  // Walk through the copies and padding of the current command.
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_nxt       = pop_cmd;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (cur_valid_r && advance) begin
      idx_nxt = SCALE_W'(idx_r + SCALE_W'(1));
    end
  end

  // Next beat of the result register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_res.ready;
    kind_nxt      = kind_r;
    blue_nxt      = blue_r;
    green_nxt     = green_r;
    red_nxt       = red_r;
    run_last_nxt  = run_last_r;
    row_end_nxt   = row_end_r;
    image_end_nxt = image_end_r;
    if (cur_valid_r && advance) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = is_pad ? KIND_PAD : KIND_PIXEL;
      blue_nxt      = is_pad ? '0 : cur_r.blue;
      green_nxt     = is_pad ? '0 : cur_r.green;
      red_nxt       = is_pad ? '0 : cur_r.red;
      run_last_nxt  = is_last;
      row_end_nxt   = is_last && cur_r.row_last;
      image_end_nxt = is_last && cur_r.image_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    kind_r      <= kind_nxt;
    blue_r      <= blue_nxt;
    green_r     <= green_nxt;
    red_r       <= red_nxt;
    run_last_r  <= run_last_nxt;
    row_end_r   <= row_end_nxt;
    image_end_r <= image_end_nxt;
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.kind      = kind_r;
  assign out_res.blue_out  = blue_r;
  assign out_res.green_out = green_r;
  assign out_res.red_out   = red_r;
  assign out_res.run_last  = run_last_r;
  assign out_res.row_end   = row_end_r;
  assign out_res.image_end = image_end_r;

  a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && image_end_r |-> row_end_r && run_last_r)
    else $error("image end without row end and run end");
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_PAD) |-> (blue_r == '0) && (green_r == '0) && (red_r == '0))
    else $error("padding byte with nonzero color");
  a_hold_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && !advance |=> $stable(idx_r) && cur_valid_r)
    else $error("copy index moved while output stalled");

endmodule

// ----- rtl/bmp_pixel_replicating_upscaler.sv -----
// Integer nearest-neighbor upscaler for 24-bit BMP pixel data. Feed each
// source row scale times, one pixel per input beat; every pixel comes out as
// scale identical copies, and the last pixel of each pass is followed by the
// zero padding bytes that bring the output row to a multiple of four bytes.
// The output delivers one beat per cycle while out_res.ready is high and the
// queue holds commands, so a pixel gives scale beats, plus zero to three
// padding beats at a row end (at most 34, since a scale of 32 never needs
// padding); that rate is set by the single result register of the back end.
// The front end accepts a pixel every cycle while its four-entry command
// queue has room. Pixels after the final row are accepted and dropped until
// reset. Write the scale, width and height registers only while the block is
// idle; zero reads as one and values above the maximum saturate.
module bmp_pixel_replicating_upscaler (
  input  logic                          clk,
  input  logic                          rst_n,
  bmpu_pix_if.sink                      in_pix,
  bmpu_res_if.source                    out_res,
  input  logic                          cfg_we,
  input  logic [bmpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmpu_pkg::CFG_W-1:0]    cfg_data
);
  import bmpu_pkg::*;

  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   pop_cmd;
  qstat_t qstat;

  // Counting and classification of incoming pixels.
  bmpu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short queue that decouples the two ends.
  bmpu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .qstat    (qstat)
  );

  // Replication and padding, one beat per cycle while the output is ready and commands wait.
  bmpu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop_cmd (pop_cmd),
    .qstat   (qstat),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

// ----- tb/sv/upscale_check_pkg.sv -----
`timescale 1ns / 1ps

package upscale_check_pkg;
  import bmpu_pkg::*;

  // Write index that decodes to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Mismatches beyond this count are only tallied.
  localparam int REPORT_LIMIT = 10;

  // One result beat, laid out like the result channel.
  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               run_last;
    logic               row_end;
    logic               image_end;
  } beat_t;

  // Tracks the upscaler's registers and counters and the beats still owed.
  class copy_ledger;
    beat_t              owed[$];
    logic [SCALE_W-1:0] scale_q;
    logic [DIM_W-1:0]   width_q;
    logic [DIM_W-1:0]   height_q;
    logic [COL_W-1:0]   col_q;
    logic [PASS_W-1:0]  pass_q;
    logic [ROW_W-1:0]   row_q;
    logic               done_q;
    int unsigned        mismatches;
    int unsigned        beats_checked;
    int unsigned        pixels_taken;
    int unsigned        pixels_dropped;
    int unsigned        writes_seen;

    function new();
      scale_q        = SCALE_W'(1);
      width_q        = DIM_W'(1);
      height_q       = DIM_W'(1);
      col_q          = '0;
      pass_q         = '0;
      row_q          = '0;
      done_q         = 1'b0;
      mismatches     = 0;
      beats_checked  = 0;
      pixels_taken   = 0;
      pixels_dropped = 0;
      writes_seen    = 0;
    endfunction

    // Zero counts as one and anything above the limit saturates.
    function int unsigned bounded(int unsigned v, int unsigned hi);
      if (v == 0) begin
        return 1;
      end
      return (v > hi) ? hi : v;
    endfunction

    // Register writes leave the counters alone.
    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      writes_seen++;
      case (idx)
        CFG_SCALE:  scale_q = data[SCALE_W-1:0];
        CFG_WIDTH:  width_q = data[DIM_W-1:0];
        CFG_HEIGHT: height_q = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Queue the copies and padding that one accepted pixel causes.
    function void take_pixel(logic [COLOR_W-1:0] b, logic [COLOR_W-1:0] g,
                             logic [COLOR_W-1:0] r);
      int unsigned s;
      int unsigned w;
      int unsigned h;
      int unsigned pad;
      int unsigned n;
      bit          row_last;
      bit          pass_last;
      bit          image_last;
      beat_t       one;
      if (done_q) begin
        pixels_dropped++;
        return;
      end
      pixels_taken++;
      s = bounded(scale_q, MAX_SCALE);
      w = bounded(width_q, MAX_WIDTH);
      h = bounded(height_q, MAX_HEIGHT);
      pad = (4 - (w * s * 3) % 4) % 4;

      // A counter at or past its last position ends the row, pass or image here.
      row_last   = (col_q >= w - 1);
      pass_last  = row_last && (pass_q >= s - 1);
      image_last = pass_last && (row_q >= h - 1);
      n = row_last ? s + pad : s;

      for (int unsigned k = 0; k < n; k++) begin
        one = '0;
        if (k < s) begin
          one.kind  = KIND_PIXEL;
          one.blue  = b;
          one.green = g;
          one.red   = r;
        end else begin
          one.kind = KIND_PAD;
        end
        if (k == n - 1) begin
          one.run_last  = 1'b1;
          one.row_end   = row_last;
          one.image_end = image_last;
        end
        owed.push_back(one);
      end

      // Advance column, pass and row.
      if (!row_last) begin
        col_q = col_q + 1'b1;
      end else begin
        col_q = '0;
        if (!pass_last) begin
          pass_q = pass_q + 1'b1;
        end else begin
          pass_q = '0;
          if (image_last) begin
            row_q  = '0;
            done_q = 1'b1;
          end else begin
            row_q = row_q + 1'b1;
          end
        end
      end
    endfunction

    // Compare one delivered beat with the oldest one owed.
    function void match_beat(beat_t got);
      beat_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("beat with nothing owed: kind %0d bgr %h/%h/%h flags %b%b%b",
                   got.kind, got.blue, got.green, got.red,
                   got.run_last, got.row_end, got.image_end);
        end
        return;
      end
      want = owed.pop_front();
      beats_checked++;
      if (got.kind !== want.kind || got.blue !== want.blue ||
          got.green !== want.green || got.red !== want.red ||
          got.run_last !== want.run_last || got.row_end !== want.row_end ||
          got.image_end !== want.image_end) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("beat %0d mismatch: kind %0d/%0d blue %h/%h green %h/%h red %h/%h",
                   beats_checked, want.kind, got.kind, want.blue, got.blue,
                   want.green, got.green, want.red, got.red);
          $display("  run_last %b/%b row_end %b/%b image_end %b/%b (expected/actual)",
                   want.run_last, got.run_last, want.row_end, got.row_end,
                   want.image_end, got.image_end);
        end
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bmpu_pkg::*;
  import upscale_check_pkg::*;

  localparam int CYCLE_LIMIT       = 600000;
  localparam int SETTLE_CYCLES     = 40;
  localparam int RANDOM_PIXELS     = 450;
  localparam int POST_IMAGE_PIXELS = 4;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          send_idle = 20;
  int unsigned          recv_idle = 62;
  int unsigned          cycles = 0;
  copy_ledger           ledger;

  bmpu_pix_if in_pix();
  bmpu_res_if out_res();

  bmp_pixel_replicating_upscaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: no finish within %0d cycles", CYCLE_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Check every beat that leaves the block.
  always @(posedge clk) begin : check_beats
    beat_t got;
    if (rst_n === 1'b1 && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      got.kind      = out_res.kind;
      got.blue      = out_res.blue_out;
      got.green     = out_res.green_out;
      got.red       = out_res.red_out;
      got.run_last  = out_res.run_last;
      got.row_end   = out_res.row_end;
      got.image_end = out_res.image_end;
      ledger.match_beat(got);
    end
  end

  // One register write; the enable stays up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    ledger.note_write(idx, data);
  endtask

  task automatic apply_config(input int unsigned sc, input int unsigned wd,
                              input int unsigned ht);
    write_reg(CFG_SCALE, CFG_W'(sc));
    write_reg(CFG_WIDTH, CFG_W'(wd));
    write_reg(CFG_HEIGHT, CFG_W'(ht));
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel beat, with random gaps ahead of it, until it is taken.
  task automatic send_pixel(input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] r);
    while ($urandom_range(99) < send_idle) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.blue  <= b;
    in_pix.green <= g;
    in_pix.red   <= r;
    @(posedge clk);
    while (in_pix.ready !== 1'b1) begin
      @(posedge clk);
    end
    ledger.take_pixel(b, g, r);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      send_pixel(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                 COLOR_W'($urandom_range(255)));
    end
  endtask

  // Drain everything owed, then give dropped pixels time to clear the block.
  task automatic settle();
    in_pix.valid <= 1'b0;
    while (ledger.owed.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phases;
    int unsigned pick;
    int unsigned sc;
    int unsigned wd;
    int unsigned ht;
    ledger = new();
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SCALE;
    cfg_data      <= '0;
    in_pix.valid  <= 1'b0;
    in_pix.blue   <= '0;
    in_pix.green  <= '0;
    in_pix.red    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two-pixel rows at scale three: two padding bytes per row. The height
    // write saturates, and a write to the unused index must change nothing.
    write_reg(CFG_SPARE, 13'h1ABC);
    apply_config(3, 2, 13'h1FFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'h0F);
    send_pixel(8'h55, 8'hAA, 8'hF0);
    send_pixel(8'h01, 8'h80, 8'h7F);
    send_pixel(8'hFE, 8'h7F, 8'h80);
    settle();

    // Zero scale (upper data bits dropped) and zero width both read as one.
    apply_config(13'h1FC0, 0, 4096);
    send_random(3);
    settle();

    // Scale above the maximum saturates; rows need no padding.
    apply_config(63, 1, 4095);
    send_random(2);
    settle();

    // Pass counter now past the last pass: the next row end closes the row.
    apply_config(2, 3, 4096);
    send_random(3);
    settle();

    // Widest rows, then a narrow width with the column already past its end.
    apply_config(1, 8191, 4096);
    send_random(6);
    settle();
    apply_config(5, 3, 4096);
    send_random(1);
    settle();

    // Random phases; the idle pattern changes at each third of the run.
    sent   = 0;
    phases = 0;
    while (sent < RANDOM_PIXELS) begin
      case (sent * 3 / RANDOM_PIXELS)
        0: begin
          send_idle = 20;
          recv_idle = 62;
        end
        1: begin
          send_idle = 62;
          recv_idle = 20;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      pick = $urandom_range(99);
      if (pick < 55) begin
        sc = $urandom_range(1, 4);
      end else if (pick < 75) begin
        sc = $urandom_range(5, 31);
      end else if (pick < 88) begin
        sc = MAX_SCALE;
      end else if (pick < 94) begin
        sc = $urandom_range(MAX_SCALE + 1, 63);
      end else begin
        sc = $urandom_range(0, 127) << SCALE_W;
      end

      pick = $urandom_range(99);
      if (pick < 70) begin
        wd = $urandom_range(1, 9);
      end else if (pick < 85) begin
        wd = $urandom_range(10, 64);
      end else if (pick < 92) begin
        wd = MAX_WIDTH;
      end else if (pick < 96) begin
        wd = $urandom_range(MAX_WIDTH + 1, 8191);
      end else begin
        wd = 0;
      end

      // Heights stay far above the rows this run can reach.
      ht = ($urandom_range(3) == 0) ? MAX_HEIGHT : $urandom_range(1000, 8191);

      apply_config(sc, wd, ht);
      pick = $urandom_range(20, 40);
      send_random(pick);
      sent += pick;
      phases++;
      settle();
    end

    // A height of zero reads as one, so the image ends with the next last pass of a row; later pixels drop.
    apply_config(2, 2, 0);
    while (!ledger.done_q) begin
      send_random(1);
    end
    send_random(POST_IMAGE_PIXELS);
    settle();

    $display("summary: %0d pixels upscaled, %0d dropped after image end, %0d beats checked",
             ledger.pixels_taken, ledger.pixels_dropped, ledger.beats_checked);
    $display("summary: %0d register writes over %0d random phases, %0d mismatches",
             ledger.writes_seen, phases, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
